[rtl/light_attenuation_radius_unit_assert.svh]
// Assertion macros shared by the light attenuation radius RTL.
`ifndef LIGHT_ATTENUATION_RADIUS_UNIT_ASSERT_SVH
`define LIGHT_ATTENUATION_RADIUS_UNIT_ASSERT_SVH
// Same-cycle implication checked on every clock edge outside reset.
`define LAR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("light attenuation radius check failed");
// Next-cycle implication checked on every clock edge outside reset.
`define LAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("light attenuation radius check failed");
`endif

[rtl/lar_pkg.sv]
// Shared constants, codes and types of the light attenuation radius unit.
`default_nettype none
package lar_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Square root unit: radicand of twice the root width.
  localparam int SQ_ROOT_W = WORD_BITS + 1;
  localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;

  // Divider unit: widest numerator magnitude is three bits above a word.
  localparam int DV_DEN_W = WORD_BITS + 1;
  localparam int DV_NUM_W = WORD_BITS + 3 + FRAC_BITS;

  localparam logic [2:0] PATH_GIVEN    = 3'd0;
  localparam logic [2:0] PATH_LINEAR   = 3'd1;
  localparam logic [2:0] PATH_ROOT     = 3'd2;
  localparam logic [2:0] PATH_FALLBACK = 3'd3;
  localparam logic [2:0] PATH_CLAMP    = 3'd4;

  localparam logic CFG_CUTOFF   = 1'b0;
  localparam logic CFG_FALLBACK = 1'b1;

  localparam logic [16:0] CUTOFF_RESET   = 17'd1966;
  localparam logic [30:0] FALLBACK_RESET = 31'd131072000;

  // Per-item fields that travel alongside the arithmetic units.
  typedef struct packed {
    logic                 kind;
    logic [WORD_BITS-1:0] given;
    logic [WORD_BITS-1:0] red;
    logic [WORD_BITS-1:0] cst;
    logic [WORD_BITS-1:0] lin;
    logic [WORD_BITS-1:0] quad;
    logic [WORD_BITS-1:0] level;
    logic [WORD_BITS-1:0] c;
    logic [WORD_BITS:0]   lnum;
    logic                 neg_disc;
    logic                 neg;
    logic [2:0]           path;
  } side_t;

endpackage
`default_nettype wire

[rtl/lar_isqrt.sv]
// Pipelined integer square root, one root bit resolved per stage.
`default_nettype none
module lar_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [lar_pkg::SQ_RAD_W-1:0]  in_rad,
  output logic                               out_valid,
  output logic [lar_pkg::SQ_ROOT_W-1:0]      out_root
);

  localparam int N  = lar_pkg::SQ_ROOT_W;
  localparam int XW = lar_pkg::SQ_RAD_W;
  localparam int RW = N + 2;

  logic [XW-1:0] x_r      [N];
  logic [RW-1:0] rem_r    [N];
  logic [N-1:0]  root_r   [N];
  logic [N-1:0]  v_r;

  logic [XW-1:0] x_cur    [N];
  logic [RW-1:0] rem_cur  [N];
  logic [N-1:0]  root_cur [N];
  logic [RW-1:0] rem_sh   [N];
  logic [RW-1:0] trial    [N];
  logic [XW-1:0] x_nxt    [N];
  logic [RW-1:0] rem_nxt  [N];
  logic [N-1:0]  root_nxt [N];

  // Each stage brings down two radicand bits and tries the next root bit.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        x_cur[k]    = in_rad;
        rem_cur[k]  = '0;
        root_cur[k] = '0;
      end else begin
        x_cur[k]    = x_r[k-1];
        rem_cur[k]  = rem_r[k-1];
        root_cur[k] = root_r[k-1];
      end
      rem_sh[k] = {rem_cur[k][RW-3:0], x_cur[k][XW-1 -: 2]};
      trial[k]  = {root_cur[k], 2'b01};
      x_nxt[k]  = {x_cur[k][XW-3:0], 2'b00};
      if (rem_sh[k] >= trial[k]) begin
        rem_nxt[k]  = rem_sh[k] - trial[k];
        root_nxt[k] = {root_cur[k][N-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh[k];
        root_nxt[k] = {root_cur[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[N-2:0], in_valid};
    end
    for (int k = 0; k < N; k++) begin
      x_r[k]    <= x_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];

endmodule
`default_nettype wire

[rtl/lar_div.sv]
// Pipelined restoring divider, one quotient bit resolved per stage.
`default_nettype none
module lar_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [lar_pkg::DV_NUM_W-1:0]  in_num,
  input  wire logic [lar_pkg::DV_DEN_W-1:0]  in_den,
  output logic                               out_valid,
  output logic [lar_pkg::DV_NUM_W-1:0]       out_quot
);

  localparam int NW = lar_pkg::DV_NUM_W;
  localparam int DW = lar_pkg::DV_DEN_W;

  // The numerator shifts out at the top while quotient bits shift in below.
  logic [NW-1:0] nq_r    [NW];
  logic [DW-1:0] rem_r   [NW];
  logic [DW-1:0] d_r     [NW];
  logic [NW-1:0] v_r;

  logic [NW-1:0] nq_cur  [NW];
  logic [DW-1:0] rem_cur [NW];
  logic [DW-1:0] d_cur   [NW];
  logic [DW:0]   rem_sh  [NW];
  logic [DW:0]   diff    [NW];
  logic [NW-1:0] nq_nxt  [NW];
  logic [DW-1:0] rem_nxt [NW];

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        nq_cur[k]  = in_num;
        rem_cur[k] = '0;
        d_cur[k]   = in_den;
      end else begin
        nq_cur[k]  = nq_r[k-1];
        rem_cur[k] = rem_r[k-1];
        d_cur[k]   = d_r[k-1];
      end
      rem_sh[k] = {rem_cur[k], nq_cur[k][NW-1]};
      diff[k]   = rem_sh[k] - {1'b0, d_cur[k]};
      if (rem_sh[k] >= {1'b0, d_cur[k]}) begin
        rem_nxt[k] = diff[k][DW-1:0];
        nq_nxt[k]  = {nq_cur[k][NW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_sh[k][DW-1:0];
        nq_nxt[k]  = {nq_cur[k][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NW-2:0], in_valid};
    end
    for (int k = 0; k < NW; k++) begin
      nq_r[k]  <= nq_nxt[k];
      rem_r[k] <= rem_nxt[k];
      d_r[k]   <= d_cur[k];
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quot  = nq_r[NW-1];

endmodule
`default_nettype wire

[rtl/light_attenuation_radius_unit.sv]
// Top level of the light attenuation radius unit.
//
//   Channel  Ports                                   Handshake
//   ------   -------------------------------------   -------------------------------
//   input    in_kind .. in_attn_quadratic            taken when start high, busy low
//   result   out_range_out, out_path_taken           out_valid strobe, one cycle
//   config   cfg_we, cfg_idx, cfg_wdata              written when cfg_we is high
//
// One item can be taken in every cycle; busy is always low.
// Each item's result passes through two square root units of 33 stages and two
// dividers of 51 stages, plus ten registered steps around them.
// Reset clears all valid bits and loads the default cutoff and fallback radius.
// The pipeline never stalls: the receiver must take each result (not enforced).
//
// Dataflow: the color magnitude (integer square root of the sum of squares) when
// in_kind is set, else the red intensity, is divided by the cutoff to give the
// light level. The discriminant of the attenuation quadratic goes through a
// second square root, and a second divider turns either the linear or the
// quadratic numerator into the radius. Fields that the arithmetic does not touch
// ride along in shift lines that match each unit's depth.
`default_nettype none
`include "light_attenuation_radius_unit_assert.svh"
module light_attenuation_radius_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_given_radius,
  input  wire logic [31:0] in_intensity_red,
  input  wire logic [31:0] in_intensity_green,
  input  wire logic [31:0] in_intensity_blue,
  input  wire logic [31:0] in_attn_constant,
  input  wire logic [31:0] in_attn_linear,
  input  wire logic [31:0] in_attn_quadratic,
  output logic             out_valid,
  output logic [31:0]      out_range_out,
  output logic [2:0]       out_path_taken,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [30:0] cfg_wdata
);

  localparam int W   = lar_pkg::WORD_BITS;
  localparam int F   = lar_pkg::FRAC_BITS;
  localparam int SQN = lar_pkg::SQ_ROOT_W;
  localparam int NW  = lar_pkg::DV_NUM_W;
  localparam int DW  = lar_pkg::DV_DEN_W;

  function automatic logic [W-1:0] mag32(input logic [W-1:0] x);
    return x[W-1] ? W'(-x) : x;
  endfunction

  // Quotient saturated to the word range, then given its sign.
  function automatic logic [W-1:0] qsat(input logic [NW-1:0] q, input logic neg);
    logic [W-1:0] lim;
    logic [W-1:0] qq;
    lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    qq  = (|q[NW-1:W] || q[W-1:0] > lim) ? lim : q[W-1:0];
    return neg ? W'(-qq) : qq;
  endfunction

  // Configuration registers.
  logic [16:0] cutoff_r;
  logic [30:0] fallback_r;
  logic [16:0] cut_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r   <= lar_pkg::CUTOFF_RESET;
      fallback_r <= lar_pkg::FALLBACK_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        lar_pkg::CFG_CUTOFF:   cutoff_r   <= cfg_wdata[16:0];
        lar_pkg::CFG_FALLBACK: fallback_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A zero cutoff behaves as the smallest step.
  assign cut_eff = (cutoff_r == '0) ? 17'd1 : cutoff_r;

  assign busy = 1'b0;

  // Input register.
  logic          s0_v_r;
  lar_pkg::side_t s0_side_r;
  logic [W-1:0]  s0_green_r;
  logic [W-1:0]  s0_blue_r;
  lar_pkg::side_t s0_side_nxt;

  always_comb begin
    s0_side_nxt       = '0;
    s0_side_nxt.kind  = in_kind;
    s0_side_nxt.given = in_given_radius;
    s0_side_nxt.red   = in_intensity_red;
    s0_side_nxt.cst   = in_attn_constant;
    s0_side_nxt.lin   = in_attn_linear;
    s0_side_nxt.quad  = in_attn_quadratic;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
    s0_side_r  <= s0_side_nxt;
    s0_green_r <= in_intensity_green;
    s0_blue_r  <= in_intensity_blue;
  end

  // Squares of the color components.
  logic           s1_v_r;
  lar_pkg::side_t s1_side_r;
  logic [2*W-1:0] s1_sqr_r;
  logic [2*W-1:0] s1_sqg_r;
  logic [2*W-1:0] s1_sqb_r;
  logic [W-1:0]   mr;
  logic [W-1:0]   mg;
  logic [W-1:0]   mb;
  logic [2*W-1:0] sqr_nxt;
  logic [2*W-1:0] sqg_nxt;
  logic [2*W-1:0] sqb_nxt;

  assign mr      = mag32(s0_side_r.red);
  assign mg      = mag32(s0_green_r);
  assign mb      = mag32(s0_blue_r);
  assign sqr_nxt = mr * mr;
  assign sqg_nxt = mg * mg;
  assign sqb_nxt = mb * mb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v_r;
    end
    s1_side_r <= s0_side_r;
    s1_sqr_r  <= sqr_nxt;
    s1_sqg_r  <= sqg_nxt;
    s1_sqb_r  <= sqb_nxt;
  end

  // Sum of squares.
  logic                          s2_v_r;
  lar_pkg::side_t                s2_side_r;
  logic [lar_pkg::SQ_RAD_W-1:0]  s2_sum_r;
  logic [lar_pkg::SQ_RAD_W-1:0]  sum_nxt;

  assign sum_nxt = {2'b00, s1_sqr_r} + {2'b00, s1_sqg_r} + {2'b00, s1_sqb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_side_r <= s1_side_r;
    s2_sum_r  <= sum_nxt;
  end

  // Magnitude square root with its side line.
  logic           sq1_v;
  logic [SQN-1:0] sq1_root;
  lar_pkg::side_t side_a_r [SQN];

  lar_isqrt u_sqrt_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_rad    (s2_sum_r),
    .out_valid (sq1_v),
    .out_root  (sq1_root)
  );

  always_ff @(posedge clk) begin
    side_a_r[0] <= s2_side_r;
    for (int i = 1; i < SQN; i++) begin
      side_a_r[i] <= side_a_r[i-1];
    end
  end

  // Intensity and the level division operands.
  logic           s3_v_r;
  lar_pkg::side_t s3_side_r;
  logic [NW-1:0]  s3_num_r;
  logic [DW-1:0]  s3_den_r;
  logic [W-1:0]   inten;
  logic [W-1:0]   root_sat;
  lar_pkg::side_t s3_side_nxt;

  assign root_sat = (|sq1_root[SQN-1:W-1]) ? {1'b0, {(W-1){1'b1}}} : sq1_root[W-1:0];
  assign inten    = side_a_r[SQN-1].kind ? root_sat : side_a_r[SQN-1].red;

  always_comb begin
    s3_side_nxt     = side_a_r[SQN-1];
    s3_side_nxt.neg = inten[W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= sq1_v;
    end
    s3_side_r <= s3_side_nxt;
    s3_num_r  <= {3'b000, mag32(inten), {F{1'b0}}};
    s3_den_r  <= {{(DW-17){1'b0}}, cut_eff};
  end

  // Level divider with its side line.
  logic           dv1_v;
  logic [NW-1:0]  dv1_q;
  lar_pkg::side_t side_b_r [NW];

  lar_div u_div_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_num    (s3_num_r),
    .in_den    (s3_den_r),
    .out_valid (dv1_v),
    .out_quot  (dv1_q)
  );

  always_ff @(posedge clk) begin
    side_b_r[0] <= s3_side_r;
    for (int i = 1; i < NW; i++) begin
      side_b_r[i] <= side_b_r[i-1];
    end
  end

  // Light level.
  logic           s4_v_r;
  lar_pkg::side_t s4_side_r;
  lar_pkg::side_t s4_side_nxt;

  always_comb begin
    s4_side_nxt       = side_b_r[NW-1];
    s4_side_nxt.level = qsat(dv1_q, side_b_r[NW-1].neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= dv1_v;
    end
    s4_side_r <= s4_side_nxt;
  end

  // Constant term of the quadratic and the linear numerator.
  logic           s5_v_r;
  lar_pkg::side_t s5_side_r;
  lar_pkg::side_t s5_side_nxt;
  logic [W:0]     cd;

  assign cd = {s4_side_r.cst[W-1], s4_side_r.cst} - {s4_side_r.level[W-1], s4_side_r.level};

  always_comb begin
    s5_side_nxt      = s4_side_r;
    s5_side_nxt.lnum = {s4_side_r.level[W-1], s4_side_r.level}
                     - {s4_side_r.cst[W-1], s4_side_r.cst};
    if (cd[W] != cd[W-1]) begin
      s5_side_nxt.c = cd[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      s5_side_nxt.c = cd[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
    end
    s5_side_r <= s5_side_nxt;
  end

  // b squared and the a times c product.
  logic           s6_v_r;
  lar_pkg::side_t s6_side_r;
  logic [2*W-1:0] s6_b2_r;
  logic [2*W-1:0] s6_ac_r;
  logic [W-1:0]   ml;
  logic [W-1:0]   mq;
  logic [W-1:0]   mc;
  logic [2*W-1:0] b2_nxt;
  logic [2*W-1:0] ac_nxt;

  assign ml     = mag32(s5_side_r.lin);
  assign mq     = mag32(s5_side_r.quad);
  assign mc     = mag32(s5_side_r.c);
  assign b2_nxt = ml * ml;
  assign ac_nxt = mq * mc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
    s6_side_r <= s5_side_r;
    s6_b2_r   <= b2_nxt;
    s6_ac_r   <= ac_nxt;
  end

  // Discriminant; a negative one marks the item as unbounded.
  logic                          s7_v_r;
  lar_pkg::side_t                s7_side_r;
  logic [lar_pkg::SQ_RAD_W-1:0]  s7_disc_r;
  logic [lar_pkg::SQ_RAD_W-1:0]  b2e;
  logic [lar_pkg::SQ_RAD_W-1:0]  ac4;
  logic                          disc_sub;
  lar_pkg::side_t                s7_side_nxt;

  assign b2e      = {2'b00, s6_b2_r};
  assign ac4      = {s6_ac_r, 2'b00};
  assign disc_sub = (s6_side_r.c != '0) && (s6_side_r.quad[W-1] == s6_side_r.c[W-1]);

  always_comb begin
    s7_side_nxt          = s6_side_r;
    s7_side_nxt.neg_disc = disc_sub && (b2e < ac4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else begin
      s7_v_r <= s6_v_r;
    end
    s7_side_r <= s7_side_nxt;
    s7_disc_r <= disc_sub ? b2e - ac4 : b2e + ac4;
  end

  // Discriminant square root with its side line.
  logic           sq2_v;
  logic [SQN-1:0] sq2_root;
  lar_pkg::side_t side_c_r [SQN];

  lar_isqrt u_sqrt_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s7_v_r),
    .in_rad    (s7_disc_r),
    .out_valid (sq2_v),
    .out_root  (sq2_root)
  );

  always_ff @(posedge clk) begin
    side_c_r[0] <= s7_side_r;
    for (int i = 1; i < SQN; i++) begin
      side_c_r[i] <= side_c_r[i-1];
    end
  end

  // Path choice and the operands of the radius division.
  logic           s8_v_r;
  lar_pkg::side_t s8_side_r;
  logic [NW-1:0]  s8_num_r;
  logic [DW-1:0]  s8_den_r;
  lar_pkg::side_t cs;
  lar_pkg::side_t s8_side_nxt;
  logic [W+2:0]   root_num;
  logic [W+2:0]   sel_num;
  logic [W:0]     sel_den;
  logic [W+2:0]   num_mag;
  logic [W:0]     den_mag;

  assign cs       = side_c_r[SQN-1];
  assign root_num = {2'b00, sq2_root} - {{3{cs.lin[W-1]}}, cs.lin};

  always_comb begin
    s8_side_nxt = cs;
    if (cs.quad == '0) begin
      sel_num = {{2{cs.lnum[W]}}, cs.lnum};
      sel_den = {cs.lin[W-1], cs.lin};
    end else begin
      sel_num = root_num;
      sel_den = {cs.quad, 1'b0};
    end
    num_mag = sel_num[W+2] ? (W+3)'(-sel_num) : sel_num;
    den_mag = sel_den[W] ? (W+1)'(-sel_den) : sel_den;
    s8_side_nxt.neg = sel_num[W+2] ^ sel_den[W];
    if (cs.given != '0) begin
      s8_side_nxt.path = lar_pkg::PATH_GIVEN;
    end else if (cs.quad == '0) begin
      s8_side_nxt.path = (cs.lin == '0) ? lar_pkg::PATH_FALLBACK : lar_pkg::PATH_LINEAR;
    end else if (cs.neg_disc) begin
      s8_side_nxt.path = lar_pkg::PATH_FALLBACK;
    end else if (root_num != '0 && root_num[W+2] != cs.quad[W-1]) begin
      s8_side_nxt.path = lar_pkg::PATH_CLAMP;
    end else begin
      s8_side_nxt.path = lar_pkg::PATH_ROOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else begin
      s8_v_r <= sq2_v;
    end
    s8_side_r <= s8_side_nxt;
    s8_num_r  <= {num_mag, {F{1'b0}}};
    s8_den_r  <= den_mag;
  end

  // Radius divider with its side line.
  logic           dv2_v;
  logic [NW-1:0]  dv2_q;
  lar_pkg::side_t side_d_r [NW];

  lar_div u_div_radius (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s8_v_r),
    .in_num    (s8_num_r),
    .in_den    (s8_den_r),
    .out_valid (dv2_v),
    .out_quot  (dv2_q)
  );

  always_ff @(posedge clk) begin
    side_d_r[0] <= s8_side_r;
    for (int i = 1; i < NW; i++) begin
      side_d_r[i] <= side_d_r[i-1];
    end
  end

  // Result register.
  logic           out_valid_r;
  logic [W-1:0]   out_range_r;
  logic [2:0]     out_path_r;
  lar_pkg::side_t ds;
  logic [W-1:0]   range_nxt;

  assign ds = side_d_r[NW-1];

  always_comb begin
    case (ds.path)
      lar_pkg::PATH_GIVEN:    range_nxt = ds.given;
      lar_pkg::PATH_FALLBACK: range_nxt = {1'b0, fallback_r};
      lar_pkg::PATH_CLAMP:    range_nxt = '0;
      default:                range_nxt = qsat(dv2_q, ds.neg);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv2_v;
    end
    out_range_r <= range_nxt;
    out_path_r  <= ds.path;
  end

  assign out_valid      = out_valid_r;
  assign out_range_out  = out_range_r;
  assign out_path_taken = out_path_r;

  // A taken item always enters the first stage.
  `LAR_ASSERT_NEXT(a_enter, start && !busy, s0_v_r)
  // A clamped root reports a zero radius.
  `LAR_ASSERT_IMP(a_clamp_zero, out_valid && out_path_taken == lar_pkg::PATH_CLAMP,
                  out_range_out == '0)
  // A passed-through radius is never zero.
  `LAR_ASSERT_IMP(a_given_nz, out_valid && out_path_taken == lar_pkg::PATH_GIVEN,
                  out_range_out != '0)
  // An unbounded light reports the configured fallback radius.
  `LAR_ASSERT_IMP(a_fallback, out_valid && out_path_taken == lar_pkg::PATH_FALLBACK,
                  out_range_out == {1'b0, fallback_r})

endmodule
`default_nettype wire
